// ===== sv/lkvc_pkg.sv =====
package lkvc_pkg;

  // Field and bus widths
  localparam int unsigned KeyW  = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned CapW  = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;

  // Command codes
  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  // Register index of the capacity register (paddr bit 2)
  localparam logic CapacityIdx = 1'b0;

  // Capacity after reset
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Value returned by a get that misses
  localparam logic [ValW-1:0] MissValue = 32'hFFFF_FFFF;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    StIdle   = 7'b000_0001,
    StScan   = 7'b000_0010,
    StDrain  = 7'b000_0100,
    StDecide = 7'b000_1000,
    StUpdate = 7'b001_0000,
    StUDrain = 7'b010_0000,
    StFinish = 7'b100_0000
  } state_e;

endpackage

// ===== sv/lkvc_ram.sv =====
module lkvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement. One get or put
// transaction is taken at a time; each returns one result (hit flag and read value, -1 on a
// get miss, 0 on a put). Key, value and recency rank of every entry live in one single-port-
// read RAM, so an operation scans all ENTRIES words, decides, then sweeps the RAM again with
// a read-modify-write of the ranks; a get that misses skips the second sweep and finishes.
// A new transaction is taken while the previous result still waits in the output register.
// Capacity (register 0) is clamped to 1..ENTRIES; lowering it below the current fill evicts
// nothing until a put of a new key replaces the least recent entry.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic signed [31:0]            key_i,
  input  logic signed [31:0]            value_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic signed [31:0]            read_value_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::AddrW-1:0]    paddr,
  input  logic [lkvc_pkg::DataW-1:0]    pwdata,
  output logic [lkvc_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = IW;
  localparam int unsigned EW = (CW > lkvc_pkg::CapW) ? CW : lkvc_pkg::CapW;
  localparam int unsigned KW = lkvc_pkg::KeyW;
  localparam int unsigned VW = lkvc_pkg::ValW;
  localparam int unsigned WW = RW + VW + KW;

  lkvc_pkg::state_e state_q, state_d;

  logic [IW-1:0]           cnt_q;
  logic                    pv_q;
  logic [IW-1:0]           pidx_q;
  logic [ENTRIES-1:0]      valid_q;
  logic [CW-1:0]           occ_q;
  logic [lkvc_pkg::CapW-1:0] cap_q;

  logic                    cmd_q;
  logic [KW-1:0]           key_q;
  logic [VW-1:0]           val_q;

  logic                    found_q, worst_q, free_q;
  logic [IW-1:0]           fidx_q, widx_q, freeidx_q;
  logic [RW-1:0]           frank_q, wrank_q;
  logic [VW-1:0]           fval_q;

  logic [IW-1:0]           tgt_q, tgt_d;
  logic [RW-1:0]           thr_q;
  logic                    all_q;
  logic [WW-1:0]           newword_q;
  logic                    res_hit_q;
  logic [VW-1:0]           res_val_q;

  logic                    out_valid_q, out_hit_q;
  logic [VW-1:0]           out_val_q;

  logic                    ram_we, ram_re;
  logic [WW-1:0]           ram_wdata, ram_rdata;
  logic [KW-1:0]           rd_key;
  logic [VW-1:0]           rd_val;
  logic [RW-1:0]           rd_rank;
  logic                    rd_valid;
  logic                    scan_eval, upd_eval;
  logic                    last_cnt, in_acc, cfg_wr, can_load, evict;
  logic [EW-1:0]           cap_ext, eff_cap;

  assign rd_key  = ram_rdata[KW-1:0];
  assign rd_val  = ram_rdata[KW+VW-1:KW];
  assign rd_rank = ram_rdata[WW-1:KW+VW];
  assign rd_valid = valid_q[pidx_q];

  assign scan_eval = pv_q && ((state_q == lkvc_pkg::StScan) || (state_q == lkvc_pkg::StDrain));
  assign upd_eval  = pv_q && ((state_q == lkvc_pkg::StUpdate) || (state_q == lkvc_pkg::StUDrain));
  assign last_cnt  = (cnt_q == IW'(ENTRIES - 1));
  assign in_stall_o = (state_q != lkvc_pkg::StIdle);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign can_load  = !out_valid_q || !out_stall_i;

  // Clamp capacity to 1..ENTRIES and compare with the fill
  assign cap_ext = EW'(cap_q);
  assign eff_cap = (cap_q == '0) ? EW'(1) :
                   ((cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext);
  assign evict   = (EW'(occ_q) >= eff_cap);
  assign tgt_d   = found_q ? fidx_q : (evict ? widx_q : freeidx_q);

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lkvc_pkg::CapacityIdx) ?
                  {{(lkvc_pkg::DataW - lkvc_pkg::CapW){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapReset;
    end else if (cfg_wr && (paddr[2] == lkvc_pkg::CapacityIdx)) begin
      cap_q <= pwdata[lkvc_pkg::CapW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      lkvc_pkg::StIdle:   if (in_acc) state_d = lkvc_pkg::StScan;
      lkvc_pkg::StScan:   if (last_cnt) state_d = lkvc_pkg::StDrain;
      lkvc_pkg::StDrain:  state_d = lkvc_pkg::StDecide;
      lkvc_pkg::StDecide: begin
        if (!found_q && (cmd_q == lkvc_pkg::CmdGet)) begin
          state_d = lkvc_pkg::StFinish;
        end else begin
          state_d = lkvc_pkg::StUpdate;
        end
      end
      lkvc_pkg::StUpdate: if (last_cnt) state_d = lkvc_pkg::StUDrain;
      lkvc_pkg::StUDrain: state_d = lkvc_pkg::StFinish;
      lkvc_pkg::StFinish: if (can_load) state_d = lkvc_pkg::StIdle;
      default:            state_d = lkvc_pkg::StIdle;
    endcase
  end

  // RAM sweep: read one word a cycle, data arrives with pidx_q
  assign ram_re = (state_q == lkvc_pkg::StScan) || (state_q == lkvc_pkg::StUpdate);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::StIdle;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= ram_re;
      if (ram_re && !last_cnt) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q;
  end

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      key_q <= key_i;
      val_q <= value_i;
    end
  end

  // Scan: first matching key, least recent valid entry, first free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      worst_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (in_acc) begin
      found_q <= 1'b0;
      worst_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (scan_eval) begin
      if (rd_valid && (rd_key == key_q) && !found_q) begin
        found_q <= 1'b1;
      end
      if (rd_valid && (!worst_q || (rd_rank > wrank_q))) begin
        worst_q <= 1'b1;
      end
      if (!rd_valid && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_eval) begin
      if (rd_valid && (rd_key == key_q) && !found_q) begin
        fidx_q  <= pidx_q;
        frank_q <= rd_rank;
        fval_q  <= rd_val;
      end
      if (rd_valid && (!worst_q || (rd_rank > wrank_q))) begin
        widx_q  <= pidx_q;
        wrank_q <= rd_rank;
      end
      if (!rd_valid && !free_q) begin
        freeidx_q <= pidx_q;
      end
    end
  end

  // Decide: target entry, aging rule, new word and result
  always_ff @(posedge clk_i) begin
    if (state_q == lkvc_pkg::StDecide) begin
      tgt_q     <= tgt_d;
      thr_q     <= frank_q;
      all_q     <= !found_q;
      res_hit_q <= found_q;
      newword_q <= {RW'(0), (cmd_q == lkvc_pkg::CmdPut) ? val_q : fval_q, key_q};
      if (cmd_q == lkvc_pkg::CmdPut) begin
        res_val_q <= '0;
      end else if (found_q) begin
        res_val_q <= fval_q;
      end else begin
        res_val_q <= lkvc_pkg::MissValue;
      end
    end
  end

  // Insert of a new key: mark the slot valid, grow the fill unless evicting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if ((state_q == lkvc_pkg::StDecide) && !found_q &&
                 (cmd_q == lkvc_pkg::CmdPut)) begin
      valid_q[tgt_d] <= 1'b1;
      if (!evict) begin
        occ_q <= occ_q + 1'b1;
      end
    end
  end

  // Update sweep: write the target, age the entries more recent than it (every valid entry for a new key)
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {RW'(rd_rank + 1'b1), rd_val, rd_key};
    if (upd_eval) begin
      if (pidx_q == tgt_q) begin
        ram_we    = 1'b1;
        ram_wdata = newword_q;
      end else if (rd_valid && (all_q || (rd_rank < thr_q))) begin
        ram_we    = 1'b1;
      end
    end
  end

  lkvc_ram #(
    .Width (WW),
    .Depth (ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pidx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == lkvc_pkg::StFinish) && can_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == lkvc_pkg::StFinish) && can_load) begin
      out_hit_q <= res_hit_q;
      out_val_q <= res_val_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_val_q;

`ifndef ASSERT_OFF
  // Fill count tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("fill count does not match valid bits");

  // RAM is written only during the update sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == lkvc_pkg::StUpdate) || (state_q == lkvc_pkg::StUDrain)))
    else $error("RAM write outside update sweep");

  // A result appears only out of the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == lkvc_pkg::StFinish))
    else $error("result without finished transaction");

  // Fill never exceeds the store size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(ENTRIES))
    else $error("fill count above store size");
`endif

endmodule
